@@ sv/lfukc_pkg.sv @@
`default_nettype none

package lfukc_pkg;

	// Cache geometry.
	localparam int LINES = 256;
	localparam int IDX_W = $clog2(LINES);
	localparam int FILL_W = $clog2(LINES + 1);

	// Hit counts saturate one below the limit, so 30 bits hold every value.
	localparam int HIT_W = 30;
	localparam logic [HIT_W-1:0] HIT_LIMIT = HIT_W'(1000000000);
	localparam logic [HIT_W-1:0] HIT_MAX = HIT_W'(999999999);

	// Key widths.
	localparam int FC_W = 40;
	localparam int TXT_W = 64;

	typedef logic [IDX_W-1:0] line_idx_t;
	typedef logic [FILL_W-1:0] fill_cnt_t;
	typedef logic [HIT_W-1:0] hit_cnt_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic frame;
		logic start_lookup;
		logic issue;
		logic update;
	} lfukc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last_issue;
	} lfukc_status_t;

endpackage

`default_nettype wire

@@ sv/lfu_keyed_cache_with_frame_pinning_core.sv @@
// Keyed text cache with least-frequently-used replacement and per-frame pinning.
// The input channel (in_valid / in_stall) carries one transfer per request: op 0
// looks up the key {font_id, color_rgba, text_tag}, op 1 starts a new frame and
// unpins every line. The output channel (out_valid / out_stall) returns one
// result per request: the serving line, hit flag, eviction flag and the error
// flag raised when a miss finds every line pinned.
// A lookup reads all 256 lines through one shared read address, one line a cycle,
// comparing the key and tracking the least-used unpinned line in the same pass.
// The result is valid once the scan has read every line and the drain step for
// the registered read data and the update step have run. A frame result is
// valid in the cycle after its transfer.
// One request is in flight at a time: in_stall stays high from the input
// transfer until the result has been transferred, so a new lookup is taken
// only after the last result has been transferred. While out_stall is high
// the result holds steady. Reset clears all hit counts, pins and the fill count
// at once through per-line valid bits; the tag memories need no clearing, so
// the block accepts requests in the first cycle after reset.
`default_nettype none

module lfu_keyed_cache_with_frame_pinning_core import lfukc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        op,
	input  wire logic [7:0]  font_id,
	input  wire logic [31:0] color_rgba,
	input  wire logic [63:0] text_tag,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       line_index,
	output logic             was_hit,
	output logic             replaced_filled,
	output logic             all_pinned_error
);

	lfukc_cmd_t    cmd;
	lfukc_status_t status;

	// Sequencer for the scan, update and result handshake.
	lfukc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status)
	);

	// Line storage, key compare and victim search.
	lfukc_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.font_id          (font_id),
		.color_rgba       (color_rgba),
		.text_tag         (text_tag),
		.line_index       (line_index),
		.was_hit          (was_hit),
		.replaced_filled  (replaced_filled),
		.all_pinned_error (all_pinned_error)
	);

endmodule

`default_nettype wire

@@ sv/lfukc_ctrl.sv @@
`default_nettype none

module lfukc_ctrl import lfukc_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic          op,
	output logic               out_valid,
	input  wire logic          out_stall,
	output lfukc_cmd_t         cmd,
	input  wire lfukc_status_t status
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SCAN   = 5'b00010,
		ST_DRAIN  = 5'b00100,
		ST_UPDATE = 5'b01000,
		ST_OUT    = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (op) begin
						cmd.frame = 1'b1;
						state_d = ST_OUT;
					end else begin
						cmd.start_lookup = 1'b1;
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				cmd.issue = 1'b1;
				if (status.last_issue) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// A scan always ends with the drain and update steps before the result shows.
	a_scan_to_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && status.last_issue) |=> (state_q == ST_DRAIN))
		else $error("scan did not move to drain after the last read");

	a_update_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE) |=> out_valid)
		else $error("result not presented after update");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.frame, cmd.start_lookup, cmd.issue, cmd.update}))
		else $error("more than one command issued in a cycle");

endmodule

`default_nettype wire

@@ sv/lfukc_dp.sv @@
`default_nettype none

module lfukc_dp import lfukc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire lfukc_cmd_t  cmd,
	output lfukc_status_t    status,
	input  wire logic [7:0]  font_id,
	input  wire logic [31:0] color_rgba,
	input  wire logic [63:0] text_tag,
	output logic [7:0]       line_index,
	output logic             was_hit,
	output logic             replaced_filled,
	output logic             all_pinned_error
);

	// Line storage.
	logic [TXT_W-1:0] txt_mem [LINES];
	logic [FC_W-1:0]  fc_mem [LINES];
	hit_cnt_t         hit_mem [LINES];
	logic [LINES-1:0] hit_valid_q;
	logic [LINES-1:0] pins_q;
	fill_cnt_t        filled_q;

	// Request key.
	logic [FC_W-1:0]  key_fc_q;
	logic [TXT_W-1:0] key_txt_q;

	// Scan read address and read stage.
	line_idx_t        raddr_q;
	logic             vld_s1;
	line_idx_t        idx_s1;
	logic [TXT_W-1:0] txt_rd_s1;
	logic [FC_W-1:0]  fc_rd_s1;
	hit_cnt_t         hit_rd_s1;
	logic             hv_s1;
	logic             pin_s1;

	// Scan results.
	logic             found_match_q;
	line_idx_t        match_idx_q;
	hit_cnt_t         match_cnt_q;
	logic             found_vic_q;
	line_idx_t        victim_q;
	hit_cnt_t         best_q;

	// Result registers.
	line_idx_t        res_idx_q;
	logic             res_hit_q;
	logic             res_repl_q;
	logic             res_err_q;

	hit_cnt_t         cnt_s1;
	logic             match_s1;
	logic             better_s1;
	logic             do_hit;
	logic             do_fill;
	line_idx_t        wr_idx;
	hit_cnt_t         hit_wdata;

	assign status.last_issue = (raddr_q == IDX_W'(LINES - 1));

	// Evaluate the line that came back from the memories.
	always_comb begin
		cnt_s1 = hv_s1 ? hit_rd_s1 : '0;
		match_s1 = vld_s1 && ({1'b0, idx_s1} < filled_q)
			&& (fc_rd_s1 == key_fc_q) && (txt_rd_s1 == key_txt_q);
		better_s1 = vld_s1 && !pin_s1 && (cnt_s1 < best_q);
	end

	// Update decisions: a hit wins over a fill; neither means every line is pinned.
	always_comb begin
		do_hit = cmd.update && found_match_q;
		do_fill = cmd.update && !found_match_q && found_vic_q;
		wr_idx = found_match_q ? match_idx_q : victim_q;
		if (found_match_q) begin
			hit_wdata = (match_cnt_q < HIT_MAX) ? match_cnt_q + HIT_W'(1) : HIT_MAX;
		end else begin
			hit_wdata = HIT_W'(1);
		end
	end

	// Tag memories: written on a fill, read during the scan.
	always_ff @(posedge clk) begin
		if (do_fill) begin
			txt_mem[wr_idx] <= key_txt_q;
			fc_mem[wr_idx] <= key_fc_q;
		end
		txt_rd_s1 <= txt_mem[raddr_q];
		fc_rd_s1 <= fc_mem[raddr_q];
	end

	// Hit count memory: written on a hit or a fill, read during the scan.
	always_ff @(posedge clk) begin
		if (do_hit || do_fill) begin
			hit_mem[wr_idx] <= hit_wdata;
		end
		hit_rd_s1 <= hit_mem[raddr_q];
	end

	// Read stage payload that rides along with the memory data.
	always_ff @(posedge clk) begin
		idx_s1 <= raddr_q;
		hv_s1 <= hit_valid_q[raddr_q];
		pin_s1 <= pins_q[raddr_q];
	end

	// Control state: valid bits, pins, fill count, scan address and flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_valid_q <= '0;
			pins_q <= '0;
			filled_q <= '0;
			raddr_q <= '0;
			vld_s1 <= 1'b0;
			found_match_q <= 1'b0;
			found_vic_q <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
			if (cmd.frame) begin
				pins_q <= '0;
			end
			if (cmd.start_lookup) begin
				raddr_q <= '0;
				found_match_q <= 1'b0;
				found_vic_q <= 1'b0;
			end else if (cmd.issue) begin
				raddr_q <= raddr_q + IDX_W'(1);
			end
			if (match_s1 && !found_match_q) begin
				found_match_q <= 1'b1;
			end
			if (better_s1) begin
				found_vic_q <= 1'b1;
			end
			if (do_hit || do_fill) begin
				hit_valid_q[wr_idx] <= 1'b1;
				pins_q[wr_idx] <= 1'b1;
			end
			if (do_fill && ({1'b0, victim_q} == filled_q)
				&& (filled_q < FILL_W'(LINES))) begin
				filled_q <= filled_q + FILL_W'(1);
			end
		end
	end

	// Key capture, scan bests and result payload.
	always_ff @(posedge clk) begin
		if (cmd.start_lookup) begin
			key_fc_q <= {font_id, color_rgba};
			key_txt_q <= text_tag;
			best_q <= HIT_LIMIT;
		end
		if (match_s1 && !found_match_q) begin
			match_idx_q <= idx_s1;
			match_cnt_q <= cnt_s1;
		end
		if (better_s1) begin
			best_q <= cnt_s1;
			victim_q <= idx_s1;
		end
		if (cmd.frame) begin
			res_idx_q <= '0;
			res_hit_q <= 1'b0;
			res_repl_q <= 1'b0;
			res_err_q <= 1'b0;
		end else if (cmd.update) begin
			res_hit_q <= found_match_q;
			res_err_q <= !found_match_q && !found_vic_q;
			res_repl_q <= do_fill && ({1'b0, victim_q} < filled_q);
			res_idx_q <= (found_match_q || found_vic_q) ? wr_idx : '0;
		end
	end

	assign line_index = 8'(res_idx_q);
	assign was_hit = res_hit_q;
	assign replaced_filled = res_repl_q;
	assign all_pinned_error = res_err_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		filled_q <= FILL_W'(LINES))
		else $error("fill count exceeds the number of lines");

	a_match_filled: assert property (@(posedge clk) disable iff (!arst_n)
		found_match_q |-> ({1'b0, match_idx_q} < filled_q))
		else $error("match recorded on an unfilled line");

	a_err_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.update && !found_match_q && !found_vic_q) |=>
			($stable(filled_q) && $stable(pins_q)))
		else $error("state changed on an all-pinned miss");

	a_frame_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.frame |=> (pins_q == '0))
		else $error("pins not cleared by a frame transfer");

endmodule

`default_nettype wire
